// ===== rtl/core/tpcb_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tpcb_pkg
// Shared types, constants and the reciprocal table of the color bleed unit.
// ----------------------------------------------------------------------------
package tpcb_pkg;

   localparam int DEFAULT_MAX_WIDTH = 2048;
   localparam int WIDTH_RESET       = 640;
   localparam int HEIGHT_RESET      = 480;
   localparam int HEIGHT_LIMIT      = 4096;

   localparam int CSR_INDEX_W  = 4;
   localparam int CSR_DATA_W   = 13;
   localparam int CFG_WIDTH_W  = 12;
   localparam int CFG_HEIGHT_W = 13;

   localparam logic [CSR_INDEX_W-1:0] CFG_IDX_WIDTH  = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] CFG_IDX_HEIGHT = 4'd1;

   localparam logic CMD_FLUSH = 1'b1;

   localparam int ROW_W       = 13;
   localparam int OUT_ROW_W   = 12;
   localparam int SUM_W       = 11;
   localparam int CNT_W       = 4;
   localparam int RECIP_W     = 19;
   localparam int RECIP_SHIFT = 18;
   localparam int PROD_W      = SUM_W + RECIP_W;

   typedef struct packed {
      logic [7:0] alpha;
      logic [7:0] blue;
      logic [7:0] green;
      logic [7:0] red;
   } pixel_type;

   typedef struct packed {
      pixel_type upper;
      pixel_type middle;
   } row_pair_type;

   typedef struct packed {
      logic capture;
      logic shift;
      logic sum;
      logic load;
   } ctrl_cmd_type;

   typedef struct packed {
      logic pixel_phase;
      logic emit;
      logic out_free;
   } ctrl_status_type;

   // ceil(2^18 / n): exact floor division for sums below 2048
   function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] n);
      logic [RECIP_W-1:0] r;
      unique case (n)
         4'd1:    r = 19'd262144;
         4'd2:    r = 19'd131072;
         4'd3:    r = 19'd87382;
         4'd4:    r = 19'd65536;
         4'd5:    r = 19'd52429;
         4'd6:    r = 19'd43691;
         4'd7:    r = 19'd37450;
         4'd8:    r = 19'd32768;
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/core/tpcb_req_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tpcb_req_if
// Input pixel channel: command and RGBA payload.
// ----------------------------------------------------------------------------
interface tpcb_req_if;
   logic       valid;
   logic       ready;
   logic       command;
   logic [7:0] red;
   logic [7:0] green;
   logic [7:0] blue;
   logic [7:0] alpha;

   modport source (output valid, command, red, green, blue, alpha, input ready);
   modport sink   (input valid, command, red, green, blue, alpha, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/tpcb_rsp_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tpcb_rsp_if
// Result pixel channel: RGBA payload and frame end flag.
// ----------------------------------------------------------------------------
interface tpcb_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_red;
   logic [7:0] out_green;
   logic [7:0] out_blue;
   logic [7:0] out_alpha;
   logic       frame_end;

   modport source (output valid, out_red, out_green, out_blue, out_alpha, frame_end,
                   input ready);
   modport sink   (input valid, out_red, out_green, out_blue, out_alpha, frame_end,
                   output ready);
endinterface
`default_nettype wire

// ===== rtl/core/tpcb_csr_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tpcb_csr_if
// Register write channel: index and data.
// ----------------------------------------------------------------------------
interface tpcb_csr_if;
   logic                             valid;
   logic                             ready;
   logic [tpcb_pkg::CSR_INDEX_W-1:0] index;
   logic [tpcb_pkg::CSR_DATA_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/tpcb_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tpcb_ctrl
// Sequencer: accept, window shift, neighbor sum, divide and output load.
// ----------------------------------------------------------------------------
module tpcb_ctrl (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   input  wire logic                      req_command,
   output logic                           req_ready,
   input  wire tpcb_pkg::ctrl_status_type status,
   output tpcb_pkg::ctrl_cmd_type         cmd
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SHIFT = 2'd1;
   localparam logic [1:0] ST_SUM   = 2'd2;
   localparam logic [1:0] ST_EMIT  = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            // drop flush items while pixels are still expected
            if (req_valid && !(status.pixel_phase && req_command == tpcb_pkg::CMD_FLUSH)) begin
               cmd.capture = 1'b1;
               state_in    = ST_SHIFT;
            end
         end
         ST_SHIFT: begin
            cmd.shift = 1'b1;
            state_in  = status.emit ? ST_SUM : ST_IDLE;
         end
         ST_SUM: begin
            cmd.sum  = 1'b1;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.load = 1'b1;
               state_in = ST_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/core/tpcb_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tpcb_datapath
// Row store, 3x3 window, position counters, neighbor sum and output register.
// ----------------------------------------------------------------------------
module tpcb_datapath #(
   parameter int MAX_WIDTH = tpcb_pkg::DEFAULT_MAX_WIDTH
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire tpcb_pkg::ctrl_cmd_type           cmd,
   output tpcb_pkg::ctrl_status_type             status,
   input  wire tpcb_pkg::pixel_type              req_pixel,
   input  wire logic                             csr_valid,
   input  wire logic [tpcb_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [tpcb_pkg::CSR_DATA_W-1:0]  csr_data,
   input  wire logic                             rsp_ready,
   output logic                                  rsp_valid,
   output tpcb_pkg::pixel_type                   rsp_pixel,
   output logic                                  rsp_frame_end
);

   localparam int COL_W   = $clog2(MAX_WIDTH);
   localparam int WV_W    = $clog2(MAX_WIDTH + 1);
   localparam int RESET_W = (tpcb_pkg::WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH
                                                                 : tpcb_pkg::WIDTH_RESET;
   localparam int ROW_W   = tpcb_pkg::ROW_W;
   localparam int OROW_W  = tpcb_pkg::OUT_ROW_W;
   localparam int SUM_W   = tpcb_pkg::SUM_W;
   localparam int CNT_W   = tpcb_pkg::CNT_W;
   localparam int PROD_W  = tpcb_pkg::PROD_W;
   localparam int SHIFT   = tpcb_pkg::RECIP_SHIFT;

   // configuration
   logic [WV_W-1:0]                        width_ff;
   logic [WV_W-1:0]                        width_in;
   logic [ROW_W-1:0]                       height_ff;
   logic [ROW_W-1:0]                       height_in;
   logic [tpcb_pkg::CFG_WIDTH_W-1:0]       width_cfg;
   logic [tpcb_pkg::CFG_HEIGHT_W-1:0]      height_cfg;
   logic                                   wr_width;
   logic                                   wr_height;

   // positions
   logic [COL_W-1:0]  in_col_ff;
   logic [ROW_W-1:0]  in_row_ff;
   logic [COL_W-1:0]  out_col_ff;
   logic [OROW_W-1:0] out_row_ff;
   logic              in_col_last;
   logic              out_col_last;
   logic              out_last;

   // row store and window
   tpcb_pkg::row_pair_type row_mem [MAX_WIDTH];
   tpcb_pkg::row_pair_type rd_data_ff;
   tpcb_pkg::pixel_type    pix_ff;
   logic [COL_W-1:0]       col_ff;
   logic                   emit_ff;
   tpcb_pkg::pixel_type    win_ff [9];

   // sum stage
   logic                col_ok [3];
   logic                row_ok [3];
   logic [SUM_W-1:0]    sum_r_ff, sum_g_ff, sum_b_ff;
   logic [SUM_W-1:0]    sum_r_in, sum_g_in, sum_b_in;
   logic [CNT_W-1:0]    cnt_ff;
   logic [CNT_W-1:0]    cnt_in;
   tpcb_pkg::pixel_type center_ff;
   logic                last_ff;

   // divide and output
   logic [tpcb_pkg::RECIP_W-1:0] recip_val;
   logic [PROD_W-1:0]            prod_r, prod_g, prod_b;
   tpcb_pkg::pixel_type          rsp_pixel_in;
   logic                         rsp_valid_ff;
   tpcb_pkg::pixel_type          rsp_pixel_ff;
   logic                         rsp_end_ff;

   assign width_cfg  = csr_data[tpcb_pkg::CFG_WIDTH_W-1:0];
   assign height_cfg = csr_data[tpcb_pkg::CFG_HEIGHT_W-1:0];
   assign wr_width   = csr_valid && csr_index == tpcb_pkg::CFG_IDX_WIDTH;
   assign wr_height  = csr_valid && csr_index == tpcb_pkg::CFG_IDX_HEIGHT;

   always_comb begin
      priority if (width_cfg == '0) begin
         width_in = WV_W'(1);
      end else if (int'(width_cfg) > MAX_WIDTH) begin
         width_in = WV_W'(MAX_WIDTH);
      end else begin
         width_in = WV_W'(width_cfg);
      end
      priority if (height_cfg == '0) begin
         height_in = ROW_W'(1);
      end else if (int'(height_cfg) > tpcb_pkg::HEIGHT_LIMIT) begin
         height_in = ROW_W'(tpcb_pkg::HEIGHT_LIMIT);
      end else begin
         height_in = ROW_W'(height_cfg);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WV_W'(RESET_W);
         height_ff <= ROW_W'(tpcb_pkg::HEIGHT_RESET);
      end else begin
         if (wr_width) begin
            width_ff <= width_in;
         end
         if (wr_height) begin
            height_ff <= height_in;
         end
      end
   end

   assign in_col_last  = WV_W'(in_col_ff) == width_ff - WV_W'(1);
   assign out_col_last = WV_W'(out_col_ff) == width_ff - WV_W'(1);
   assign out_last     = out_col_last && ROW_W'(out_row_ff) == height_ff - ROW_W'(1);

   always_ff @(posedge clock) begin
      if (reset || wr_width || wr_height) begin
         in_col_ff  <= '0;
         in_row_ff  <= '0;
         out_col_ff <= '0;
         out_row_ff <= '0;
      end else if (cmd.capture) begin
         if (in_col_last) begin
            in_col_ff <= '0;
            in_row_ff <= in_row_ff + ROW_W'(1);
         end else begin
            in_col_ff <= in_col_ff + COL_W'(1);
         end
      end else if (cmd.load) begin
         if (last_ff) begin
            in_col_ff  <= '0;
            in_row_ff  <= '0;
            out_col_ff <= '0;
            out_row_ff <= '0;
         end else if (out_col_last) begin
            out_col_ff <= '0;
            out_row_ff <= out_row_ff + OROW_W'(1);
         end else begin
            out_col_ff <= out_col_ff + COL_W'(1);
         end
      end
   end

   // capture item, read row store, then shift window and write back
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         rd_data_ff <= row_mem[in_col_ff];
         col_ff     <= in_col_ff;
         pix_ff     <= status.pixel_phase ? req_pixel : '0;
         emit_ff    <= in_row_ff > ROW_W'(1) || (in_row_ff == ROW_W'(1) && in_col_ff != '0);
      end
      if (cmd.shift) begin
         row_mem[col_ff] <= '{upper: rd_data_ff.middle, middle: pix_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.shift) begin
         for (int k = 0; k < 6; k++) begin
            win_ff[k] <= win_ff[k+3];
         end
         win_ff[6] <= rd_data_ff.upper;
         win_ff[7] <= rd_data_ff.middle;
         win_ff[8] <= pix_ff;
      end
   end

   assign col_ok[0] = out_col_ff != '0;
   assign col_ok[1] = 1'b1;
   assign col_ok[2] = !out_col_last;
   assign row_ok[0] = out_row_ff != '0;
   assign row_ok[1] = 1'b1;
   assign row_ok[2] = ROW_W'(out_row_ff) != height_ff - ROW_W'(1);

   always_comb begin
      sum_r_in = '0;
      sum_g_in = '0;
      sum_b_in = '0;
      cnt_in   = '0;
      for (int cc = 0; cc < 3; cc++) begin
         for (int rr = 0; rr < 3; rr++) begin
            if (col_ok[cc] && row_ok[rr] && win_ff[cc*3+rr].alpha != '0) begin
               sum_r_in = sum_r_in + SUM_W'(win_ff[cc*3+rr].red);
               sum_g_in = sum_g_in + SUM_W'(win_ff[cc*3+rr].green);
               sum_b_in = sum_b_in + SUM_W'(win_ff[cc*3+rr].blue);
               cnt_in   = cnt_in + CNT_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.sum) begin
         sum_r_ff  <= sum_r_in;
         sum_g_ff  <= sum_g_in;
         sum_b_ff  <= sum_b_in;
         cnt_ff    <= cnt_in;
         center_ff <= win_ff[4];
         last_ff   <= out_last;
      end
   end

   assign recip_val = tpcb_pkg::recip(cnt_ff);
   assign prod_r    = PROD_W'(sum_r_ff) * PROD_W'(recip_val);
   assign prod_g    = PROD_W'(sum_g_ff) * PROD_W'(recip_val);
   assign prod_b    = PROD_W'(sum_b_ff) * PROD_W'(recip_val);

   always_comb begin
      rsp_pixel_in = center_ff;
      if (center_ff.alpha == '0 && cnt_ff != '0) begin
         rsp_pixel_in.red   = prod_r[SHIFT+7:SHIFT];
         rsp_pixel_in.green = prod_g[SHIFT+7:SHIFT];
         rsp_pixel_in.blue  = prod_b[SHIFT+7:SHIFT];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         rsp_pixel_ff <= rsp_pixel_in;
         rsp_end_ff   <= last_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_pixel     = rsp_pixel_ff;
   assign rsp_frame_end = rsp_end_ff;

   assign status.pixel_phase = in_row_ff < height_ff;
   assign status.emit        = emit_ff;
   assign status.out_free    = !rsp_valid_ff || rsp_ready;

endmodule
`default_nettype wire

// ===== rtl/core/transparent_pixel_color_bleed_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// transparent_pixel_color_bleed_unit
// Fills fully transparent pixels with the average color of their opaque
// 3x3 neighbors; results trail the input by one row plus one pixel.
// ----------------------------------------------------------------------------
//  channel  dir  handshake      payload
//  req_bus  in   valid/ready    command, red, green, blue, alpha
//  rsp_bus  out  valid/ready    out_red, out_green, out_blue, out_alpha, frame_end
//  csr_bus  in   valid/ready    index, data (ready always high)
//
//  Flush item in pixel phase: dropped in idle. Others: idle, then shift (row
//  store read/write); with a result, also sum and emit (neighbor sum, reciprocal
//  multiply); emit waits on a full output register. Only idle accepts items.
//  Row store needs no clearing pass; out-of-image entries are masked.
//  A register write restarts the frame; write only while idle.
// ----------------------------------------------------------------------------
module transparent_pixel_color_bleed_unit #(
   parameter int MAX_WIDTH = tpcb_pkg::DEFAULT_MAX_WIDTH
) (
   input wire logic  clock,
   input wire logic  reset,
   tpcb_req_if.sink  req_bus,
   tpcb_rsp_if.source rsp_bus,
   tpcb_csr_if.sink  csr_bus
);

   tpcb_pkg::ctrl_cmd_type    cmd;
   tpcb_pkg::ctrl_status_type status;
   tpcb_pkg::pixel_type       req_pixel;
   tpcb_pkg::pixel_type       rsp_pixel;
   logic                      req_ready;
   logic                      rsp_valid;
   logic                      rsp_frame_end;

   assign req_pixel.red   = req_bus.red;
   assign req_pixel.green = req_bus.green;
   assign req_pixel.blue  = req_bus.blue;
   assign req_pixel.alpha = req_bus.alpha;

   tpcb_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_bus.valid),
      .req_command (req_bus.command),
      .req_ready   (req_ready),
      .status      (status),
      .cmd         (cmd)
   );

   tpcb_datapath #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .req_pixel     (req_pixel),
      .csr_valid     (csr_bus.valid),
      .csr_index     (csr_bus.index),
      .csr_data      (csr_bus.data),
      .rsp_ready     (rsp_bus.ready),
      .rsp_valid     (rsp_valid),
      .rsp_pixel     (rsp_pixel),
      .rsp_frame_end (rsp_frame_end)
   );

   assign req_bus.ready     = req_ready;
   assign csr_bus.ready     = 1'b1;
   assign rsp_bus.valid     = rsp_valid;
   assign rsp_bus.out_red   = rsp_pixel.red;
   assign rsp_bus.out_green = rsp_pixel.green;
   assign rsp_bus.out_blue  = rsp_pixel.blue;
   assign rsp_bus.out_alpha = rsp_pixel.alpha;
   assign rsp_bus.frame_end = rsp_frame_end;

`ifndef SYNTH
   a_cmd_onehot : assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.capture, cmd.shift, cmd.sum, cmd.load}))
      else $error("more than one datapath command at once");

   a_load_free : assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> status.out_free)
      else $error("output register overwritten");

   a_capture_accept : assert property (@(posedge clock) disable iff (reset)
      cmd.capture |-> (req_bus.valid && req_bus.ready))
      else $error("item captured without handshake");

   a_rsp_from_load : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_bus.valid) |-> $past(cmd.load))
      else $error("result raised without a load");
`endif

endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Streams directed and random RGBA frames through the color bleed unit under
// random source gaps and sink stalls, predicts every bled pixel from its own
// copy of the row stores and 3x3 window, and compares each result in order.
// ----------------------------------------------------------------------------
module testbench;
   import tpcb_pkg::*;

   localparam logic                   CMD_PIXEL      = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CFG_IDX_UNUSED = 4'hF;
   localparam int IDLE_PCT     = 35;
   localparam int RANDOM_ITEMS = 1500;
   localparam int CLAMP_ITEMS  = 100;
   localparam int DRAIN_CYCLES = 16;
   localparam int CYCLE_LIMIT  = 2_000_000;

   typedef struct packed {
      logic      command;
      pixel_type px;
   } stream_item_type;

   typedef struct packed {
      pixel_type px;
      logic      frame_end;
   } bled_pixel_type;

   logic clock;
   logic reset;

   tpcb_req_if req_bus ();
   tpcb_rsp_if rsp_bus ();
   tpcb_csr_if csr_bus ();

   transparent_pixel_color_bleed_unit u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   stream_item_type frame_items [$];
   bled_pixel_type  bled_pixels_due [$];
   stream_item_type send_item;
   stream_item_type taken_item;
   bled_pixel_type  due_pixel;

   logic [CFG_WIDTH_W-1:0]  width_reg;
   logic [CFG_HEIGHT_W-1:0] height_reg;
   pixel_type               upper_row [DEFAULT_MAX_WIDTH];
   pixel_type               middle_row [DEFAULT_MAX_WIDTH];
   pixel_type               window_px [9];
   int unsigned             in_pos;
   int unsigned             out_pos;

   bit          calm;
   int unsigned random_items;
   int unsigned mismatch_count;
   int unsigned cycle_count;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int unsigned frame_width();
      if (width_reg == 0) return 1;
      if (width_reg > DEFAULT_MAX_WIDTH) return DEFAULT_MAX_WIDTH;
      return width_reg;
   endfunction

   function automatic int unsigned frame_height();
      if (height_reg == 0) return 1;
      if (height_reg > HEIGHT_LIMIT) return HEIGHT_LIMIT;
      return height_reg;
   endfunction

   function automatic pixel_type rgba(input logic [7:0] r, input logic [7:0] g,
                                      input logic [7:0] b, input logic [7:0] a);
      pixel_type px;
      px.red   = r;
      px.green = g;
      px.blue  = b;
      px.alpha = a;
      return px;
   endfunction

   function automatic pixel_type random_pixel(input int unsigned zero_pct);
      pixel_type px;
      px.red   = 8'($urandom);
      px.green = 8'($urandom);
      px.blue  = 8'($urandom);
      px.alpha = ($urandom_range(99) < zero_pct) ? 8'd0 : 8'($urandom_range(255, 1));
      return px;
   endfunction

   function automatic void queue_item(input logic cmd, input pixel_type px);
      stream_item_type item;
      item.command = cmd;
      item.px      = px;
      frame_items.push_back(item);
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("%0t ns: mismatch on %s, got %0d, want %0d", $time, what, got, want);
      mismatch_count++;
   endtask

   // one accepted item through the 3x3 bleed; may push one expected pixel
   task automatic bleed_step(input stream_item_type item);
      int unsigned    w, h, total, start, col, p, ro, co;
      int unsigned    sr, sg, sb, cnt, c, k;
      pixel_type      pix, v;
      bled_pixel_type res;
      w     = frame_width();
      h     = frame_height();
      total = w * h;
      start = in_pos;
      pix   = '0;
      if (start < total) begin
         if (item.command == CMD_FLUSH) return;
         pix = item.px;
      end
      col = start % w;
      for (c = 0; c < 6; c++) window_px[c] = window_px[c + 3];
      window_px[6]    = upper_row[col];
      window_px[7]    = middle_row[col];
      window_px[8]    = pix;
      upper_row[col]  = middle_row[col];
      middle_row[col] = pix;
      in_pos = start + 1;
      if (start < w + 1 || out_pos >= total) return;

      p  = out_pos;
      ro = p / w;
      co = p % w;
      res.px = window_px[4];
      if (res.px.alpha == 0) begin
         sr  = 0;
         sg  = 0;
         sb  = 0;
         cnt = 0;
         for (c = 0; c < 3; c++) begin
            for (k = 0; k < 3; k++) begin
               v = window_px[c * 3 + k];
               if (!((c == 0 && co == 0) || (c == 2 && co + 1 >= w) ||
                     (k == 0 && ro == 0) || (k == 2 && ro + 1 >= h) ||
                     v.alpha == 0)) begin
                  sr += v.red;
                  sg += v.green;
                  sb += v.blue;
                  cnt++;
               end
            end
         end
         if (cnt != 0) begin
            res.px.red   = 8'(sr / cnt);
            res.px.green = 8'(sg / cnt);
            res.px.blue  = 8'(sb / cnt);
         end
      end
      out_pos = p + 1;
      res.frame_end = (out_pos == total);
      bled_pixels_due.push_back(res);
      if (res.frame_end) begin
         in_pos  = 0;
         out_pos = 0;
      end
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= value;
      do @(posedge clock); while (!csr_bus.ready);
      if (idx == CFG_IDX_WIDTH) begin
         width_reg = value[CFG_WIDTH_W-1:0];
         in_pos    = 0;
         out_pos   = 0;
      end else if (idx == CFG_IDX_HEIGHT) begin
         height_reg = value[CFG_HEIGHT_W-1:0];
         in_pos     = 0;
         out_pos    = 0;
      end
      csr_bus.valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic wait_idle();
      do @(negedge clock);
      while (frame_items.size() != 0 || req_bus.valid || bled_pixels_due.size() != 0);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // full frame plus drain, or a cut-off frame when partial is set
   task automatic queue_frame(input bit partial);
      int unsigned w, n_pix, n_keep, zero_pct, i;
      w        = frame_width();
      n_pix    = w * frame_height();
      zero_pct = $urandom_range(100);
      n_keep   = partial ? $urandom_range(n_pix + w, 1) : n_pix + w + 1;
      for (i = 0; i < n_keep; i++) begin
         if (i < n_pix) begin
            if ($urandom_range(99) < 4) queue_item(CMD_FLUSH, random_pixel(50));
            queue_item(CMD_PIXEL, random_pixel(zero_pct));
         end else if ($urandom_range(99) < 10) begin
            queue_item(CMD_PIXEL, random_pixel(50));
         end else begin
            queue_item(CMD_FLUSH, random_pixel(50));
         end
         random_items++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            taken_item.command  = req_bus.command;
            taken_item.px.red   = req_bus.red;
            taken_item.px.green = req_bus.green;
            taken_item.px.blue  = req_bus.blue;
            taken_item.px.alpha = req_bus.alpha;
            bleed_step(taken_item);
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (frame_items.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
               send_item = frame_items.pop_front();
               req_bus.valid   <= 1'b1;
               req_bus.command <= send_item.command;
               req_bus.red     <= send_item.px.red;
               req_bus.green   <= send_item.px.green;
               req_bus.blue    <= send_item.px.blue;
               req_bus.alpha   <= send_item.px.alpha;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (bled_pixels_due.size() == 0) begin
               report_mismatch("unexpected item", 1, 0);
            end else begin
               due_pixel = bled_pixels_due.pop_front();
               if (rsp_bus.out_red !== due_pixel.px.red)
                  report_mismatch("out_red", rsp_bus.out_red, due_pixel.px.red);
               if (rsp_bus.out_green !== due_pixel.px.green)
                  report_mismatch("out_green", rsp_bus.out_green, due_pixel.px.green);
               if (rsp_bus.out_blue !== due_pixel.px.blue)
                  report_mismatch("out_blue", rsp_bus.out_blue, due_pixel.px.blue);
               if (rsp_bus.out_alpha !== due_pixel.px.alpha)
                  report_mismatch("out_alpha", rsp_bus.out_alpha, due_pixel.px.alpha);
               if (rsp_bus.frame_end !== due_pixel.frame_end)
                  report_mismatch("frame_end", rsp_bus.frame_end, due_pixel.frame_end);
            end
         end
         rsp_bus.ready <= calm || $urandom_range(99) >= IDLE_PCT;
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAIL transparent_pixel_color_bleed_unit");
         $finish;
      end
   end

   initial begin
      int unsigned             i, k, w, h, sel, frames;
      int unsigned             phase;
      logic [CSR_DATA_W-1:0]   w_data, h_data;

      reset           = 1'b1;
      req_bus.valid   = 1'b0;
      req_bus.command = CMD_PIXEL;
      req_bus.red     = '0;
      req_bus.green   = '0;
      req_bus.blue    = '0;
      req_bus.alpha   = '0;
      rsp_bus.ready   = 1'b0;
      csr_bus.valid   = 1'b0;
      csr_bus.index   = CFG_IDX_WIDTH;
      csr_bus.data    = '0;
      calm            = 1'b0;
      mismatch_count  = 0;
      cycle_count     = 0;
      random_items    = 0;
      width_reg       = CFG_WIDTH_W'(WIDTH_RESET);
      height_reg      = CFG_HEIGHT_W'(HEIGHT_RESET);
      in_pos          = 0;
      out_pos         = 0;
      for (i = 0; i < DEFAULT_MAX_WIDTH; i++) begin
         upper_row[i]  = '0;
         middle_row[i] = '0;
      end
      for (i = 0; i < 9; i++) window_px[i] = '0;

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // 3x3 frame: transparent center with eight opaque neighbors at full red
      write_reg(CFG_IDX_WIDTH, 13'd3);
      write_reg(CFG_IDX_HEIGHT, 13'd3);
      queue_item(CMD_PIXEL, rgba(8'd255, 8'd255, 8'd255, 8'd255));
      queue_item(CMD_PIXEL, rgba(8'd255, 8'd0, 8'd64, 8'd255));
      queue_item(CMD_PIXEL, rgba(8'd255, 8'd255, 8'd255, 8'd17));
      queue_item(CMD_PIXEL, rgba(8'd255, 8'd128, 8'd1, 8'd128));
      queue_item(CMD_FLUSH, rgba(8'hA5, 8'h5A, 8'hC3, 8'h00));
      queue_item(CMD_PIXEL, rgba(8'd18, 8'd52, 8'd86, 8'd0));
      queue_item(CMD_PIXEL, rgba(8'd255, 8'd255, 8'd255, 8'd1));
      queue_item(CMD_PIXEL, rgba(8'd255, 8'd0, 8'd128, 8'd64));
      queue_item(CMD_PIXEL, rgba(8'd255, 8'd255, 8'd255, 8'd255));
      queue_item(CMD_PIXEL, rgba(8'd255, 8'd7, 8'd0, 8'd200));
      queue_item(CMD_FLUSH, rgba(8'd0, 8'd0, 8'd0, 8'd0));
      queue_item(CMD_FLUSH, rgba(8'd0, 8'd0, 8'd0, 8'd0));
      queue_item(CMD_PIXEL, rgba(8'hFF, 8'h00, 8'hFF, 8'h00));
      queue_item(CMD_FLUSH, rgba(8'hFF, 8'hFF, 8'hFF, 8'hFF));
      wait_idle();

      // zero sizes act as one: lone transparent pixel with no opaque neighbor
      write_reg(CFG_IDX_WIDTH, 13'd0);
      write_reg(CFG_IDX_HEIGHT, 13'd0);
      queue_item(CMD_PIXEL, rgba(8'd0, 8'd0, 8'd0, 8'd0));
      queue_item(CMD_FLUSH, rgba(8'd0, 8'd0, 8'd0, 8'd0));
      queue_item(CMD_FLUSH, rgba(8'd0, 8'd0, 8'd0, 8'd0));
      wait_idle();

      // cut a frame short, then restart it with a register write
      write_reg(CFG_IDX_WIDTH, 13'd3);
      write_reg(CFG_IDX_HEIGHT, 13'd3);
      for (i = 0; i < 5; i++) queue_item(CMD_PIXEL, random_pixel(50));
      wait_idle();

      // short cut-off frames at and beyond each size limit
      for (k = 0; k < 4; k++) begin
         case (k)
            0: begin w_data = 13'h1FFF; h_data = 13'd1;    end
            1: begin w_data = 13'd1;    h_data = 13'h1FFF; end
            2: begin w_data = 13'd2048; h_data = 13'd1;    end
            default: begin w_data = 13'd1; h_data = 13'd4096; end
         endcase
         write_reg(CFG_IDX_WIDTH, w_data);
         write_reg(CFG_IDX_HEIGHT, h_data);
         for (i = 0; i < CLAMP_ITEMS; i++) queue_item(CMD_PIXEL, random_pixel(50));
         wait_idle();
      end

      random_items = 0;
      phase        = 0;
      while (random_items < RANDOM_ITEMS) begin
         calm = (phase >= 6 && phase < 10);
         if ($urandom_range(9) == 0) write_reg(CFG_IDX_UNUSED, CSR_DATA_W'($urandom));
         sel = $urandom_range(99);
         if (sel < 75) begin
            w = $urandom_range(12, 1);
            h = $urandom_range(8, 1);
         end else if (sel < 93) begin
            w = $urandom_range(64, 13);
            h = $urandom_range(6, 1);
         end else begin
            w = $urandom_range(2, 0);
            h = $urandom_range(64, 0);
         end
         w_data = CSR_DATA_W'(w);
         w_data[CSR_DATA_W-1] = 1'($urandom_range(1));
         h_data = CSR_DATA_W'(h);
         if ($urandom_range(1) == 0) begin
            write_reg(CFG_IDX_WIDTH, w_data);
            write_reg(CFG_IDX_HEIGHT, h_data);
         end else begin
            write_reg(CFG_IDX_HEIGHT, h_data);
            write_reg(CFG_IDX_WIDTH, w_data);
         end
         frames = $urandom_range(3, 1);
         for (i = 0; i < frames; i++)
            queue_frame(i == frames - 1 && $urandom_range(9) == 0);
         wait_idle();
         phase++;
      end
      calm = 1'b0;

      wait_idle();
      if (mismatch_count == 0) begin
         $display("PASS transparent_pixel_color_bleed_unit");
      end else begin
         $display("FAIL transparent_pixel_color_bleed_unit");
      end
      $finish;
   end

endmodule

// ===== transparent_pixel_color_bleed_unit.f =====
rtl/core/tpcb_pkg.sv
rtl/core/tpcb_req_if.sv
rtl/core/tpcb_rsp_if.sv
rtl/core/tpcb_csr_if.sv
rtl/core/tpcb_ctrl.sv
rtl/core/tpcb_datapath.sv
rtl/core/transparent_pixel_color_bleed_unit.sv
tb/testbench.sv
